// ----- rtl/tccc_pkg.sv -----
`timescale 1ns / 1ps

package tccc_pkg;

  localparam int unsigned MaxColumnsDef = 256;
  localparam int unsigned MaxRowsDef    = 256;

  localparam logic [8:0]  ColumnsReset   = 9'd80;
  localparam logic [8:0]  RowsReset      = 9'd25;
  localparam logic [23:0] TextColorReset = 24'hFFFFFF;

  localparam logic [7:0]  CharLf    = 8'd10;
  localparam logic [7:0]  CharCr    = 8'd13;
  localparam logic [7:0]  CharBs    = 8'd8;
  localparam logic [7:0]  CharSpace = 8'd32;
  localparam logic [23:0] ColorBlack = 24'h000000;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    CmdDraw   = 1'b0,
    CmdScroll = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegColumns   = 2'd0,
    RegRows      = 2'd1,
    RegTextColor = 2'd2
  } reg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  glyph;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [23:0] color;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       e0;
    res_t       e1;
  } push_t;

  typedef struct packed {
    logic [QCntW-1:0] level;
    logic             room_two;
  } q_status_t;

endpackage

// ----- rtl/tccc_cursor.sv -----
`timescale 1ns / 1ps

module tccc_cursor #(
  parameter int unsigned MAX_COLUMNS = tccc_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = tccc_pkg::MaxRowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_char_i,
  output logic                in_ready_o,
  input  logic [8:0]          columns_i,
  input  logic [8:0]          rows_i,
  input  logic [23:0]         text_color_i,
  input  tccc_pkg::q_status_t status_i,
  output tccc_pkg::push_t     push_o
);

  localparam logic [8:0] MaxCols = 9'(MAX_COLUMNS);
  localparam logic [8:0] MaxRows = 9'(MAX_ROWS);

  logic       char_valid_q, char_valid_d;
  logic [7:0] char_q, char_d;
  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic       step_en;
  logic [8:0] w, h, wm1, col_p1, row_p1;
  logic [1:0] n;
  tccc_pkg::res_t e0, e1;

  assign step_en    = char_valid_q & status_i.room_two;
  assign in_ready_o = ~char_valid_q | step_en;

  always_comb begin
    char_valid_d = char_valid_q;
    char_d       = char_q;
    if (in_ready_o) begin
      char_valid_d = in_valid_i;
      char_d       = in_char_i;
    end
  end

  always_comb begin
    if (columns_i == 9'd0) begin
      w = 9'd1;
    end else if (columns_i > MaxCols) begin
      w = MaxCols;
    end else begin
      w = columns_i;
    end
    if (rows_i == 9'd0) begin
      h = 9'd1;
    end else if (rows_i > MaxRows) begin
      h = MaxRows;
    end else begin
      h = rows_i;
    end
    wm1    = w - 9'd1;
    col_p1 = {1'b0, col_q} + 9'd1;
    row_p1 = {1'b0, row_q} + 9'd1;

    col_d = col_q;
    row_d = row_q;
    n     = 2'd0;
    e0    = '0;
    e1    = '0;
    e1.cmd  = tccc_pkg::CmdScroll;
    e1.last = 1'b1;

    case (char_q)
      tccc_pkg::CharLf: begin
        col_d = 8'd0;
        if (row_p1 >= h) begin
          e0.cmd  = tccc_pkg::CmdScroll;
          e0.last = 1'b1;
          n       = 2'd1;
        end else begin
          row_d = row_p1[7:0];
        end
      end
      tccc_pkg::CharCr: begin
        col_d = 8'd0;
      end
      tccc_pkg::CharBs: begin
        if (col_q != 8'd0) begin
          col_d = col_q - 8'd1;
          n     = 2'd1;
        end else if (row_q != 8'd0) begin
          row_d = row_q - 8'd1;
          col_d = wm1[7:0];
          n     = 2'd1;
        end
        e0.cmd   = tccc_pkg::CmdDraw;
        e0.glyph = tccc_pkg::CharSpace;
        e0.col   = col_d;
        e0.row   = row_d;
        e0.color = tccc_pkg::ColorBlack;
        e0.last  = 1'b1;
      end
      default: begin
        if (({1'b0, col_q} < w) && ({1'b0, row_q} < h)) begin
          e0.cmd   = tccc_pkg::CmdDraw;
          e0.glyph = char_q;
          e0.col   = col_q;
          e0.row   = row_q;
          e0.color = text_color_i;
          e0.last  = 1'b1;
          n        = 2'd1;
          if (col_p1 >= w) begin
            col_d = 8'd0;
            if (row_p1 >= h) begin
              e0.last = 1'b0;
              n       = 2'd2;
            end else begin
              row_d = row_p1[7:0];
            end
          end else begin
            col_d = col_p1[7:0];
          end
        end
      end
    endcase
  end

  assign push_o.count = step_en ? n : 2'd0;
  assign push_o.e0    = e0;
  assign push_o.e1    = e1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_valid_q <= 1'b0;
      col_q        <= 8'd0;
      row_q        <= 8'd0;
    end else begin
      char_valid_q <= char_valid_d;
      if (step_en) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

// ----- rtl/tccc_queue.sv -----
`timescale 1ns / 1ps

module tccc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tccc_pkg::push_t     push_i,
  input  logic                ready_i,
  output logic                valid_o,
  output tccc_pkg::res_t      head_o,
  output tccc_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = tccc_pkg::QPtrW;
  localparam int unsigned CntW = tccc_pkg::QCntW;

  tccc_pkg::res_t mem_q [tccc_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] level_q, level_d;
  logic            pop;

  assign valid_o = level_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    level_d  = level_q + CntW'(push_i.count) - CntW'(pop);
  end

  assign status_o.level    = level_q;
  assign status_o.room_two = level_q <= CntW'(tccc_pkg::QDepth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.e1;
    end
  end

endmodule

// ----- rtl/text_console_cursor_controller.sv -----
// flow: a character is registered on acceptance and decoded into the result queue once
//   the queue has room for two entries; its first command is valid once it is written
//   into the queue and can then be taken
// throughput: one character per cycle while the output drains; a character that wraps
//   and scrolls gives two commands, which leave through the queue port one at a time
// reset: cursor at origin, 80 columns, 25 rows, white text, result queue empty
`timescale 1ns / 1ps

module text_console_cursor_controller #(
  parameter int unsigned MAX_COLUMNS = tccc_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = tccc_pkg::MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // glyph, cell_column, cell_row, draw_color
  output logic        m_axis_tuser_o,   // command
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [8:0]  columns_q, rows_q;
  logic [23:0] text_color_q;
  logic        cfg_we;
  tccc_pkg::reg_e      reg_sel;
  tccc_pkg::push_t     push_w;
  tccc_pkg::q_status_t q_status;
  tccc_pkg::res_t      head;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i & pready_o;
  assign reg_sel  = tccc_pkg::reg_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= tccc_pkg::ColumnsReset;
      rows_q       <= tccc_pkg::RowsReset;
      text_color_q <= tccc_pkg::TextColorReset;
    end else if (cfg_we) begin
      case (reg_sel)
        tccc_pkg::RegColumns:   columns_q    <= pwdata_i[8:0];
        tccc_pkg::RegRows:      rows_q       <= pwdata_i[8:0];
        tccc_pkg::RegTextColor: text_color_q <= pwdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tccc_pkg::RegColumns:   prdata_o = {23'd0, columns_q};
      tccc_pkg::RegRows:      prdata_o = {23'd0, rows_q};
      tccc_pkg::RegTextColor: prdata_o = {8'd0, text_color_q};
      default:                prdata_o = 32'd0;
    endcase
  end

  tccc_cursor #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_char_i   (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .columns_i   (columns_q),
    .rows_i      (rows_q),
    .text_color_i(text_color_q),
    .status_i    (q_status),
    .push_o      (push_w)
  );

  tccc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head),
    .status_o(q_status)
  );

  assign m_axis_tdata_o = {head.color, head.row, head.col, head.glyph};
  assign m_axis_tuser_o = head.cmd;
  assign m_axis_tlast_o = head.last;

  // queue never overfills
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.level <= 3'(tccc_pkg::QDepth))
    else $error("result queue overflow");

  // a two-command transaction is a draw followed by the closing scroll
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w.count == 2'd2 |->
      push_w.e1.cmd == tccc_pkg::CmdScroll && push_w.e0.cmd == tccc_pkg::CmdDraw &&
      !push_w.e0.last && push_w.e1.last)
    else $error("bad two-command push");

  // a scroll always closes its character
  a_scroll_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("scroll without last");

  // a push only happens with room for two entries
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w.count != 2'd0 |-> q_status.room_two)
    else $error("push without room");

endmodule

// ----- test/tb_text_console_cursor_controller.sv -----
`timescale 1ns / 1ps

module tb_text_console_cursor_controller;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // glyph, cell_column, cell_row, draw_color
  logic        m_axis_tuser;        // command
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // cursor and register shadow
  logic [8:0]  cfg_columns = tccc_pkg::ColumnsReset;
  logic [8:0]  cfg_rows = tccc_pkg::RowsReset;
  logic [23:0] cfg_color = tccc_pkg::TextColorReset;
  logic [7:0]  cur_col = '0;
  logic [7:0]  cur_row = '0;

  tccc_pkg::res_t expected_cmds[$];
  tccc_pkg::res_t got_cmd;
  tccc_pkg::res_t want_cmd;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  text_console_cursor_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int unsigned eff_size(logic [8:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic tccc_pkg::res_t make_cmd(tccc_pkg::cmd_e cmd, logic [7:0] glyph,
                                              logic [7:0] col, logic [7:0] row,
                                              logic [23:0] color);
    tccc_pkg::res_t r;
    r.cmd   = cmd;
    r.glyph = glyph;
    r.col   = col;
    r.row   = row;
    r.color = color;
    r.last  = 1'b0;
    return r;
  endfunction

  // moves to the start of the next line, returns 1 when the screen scrolls
  function automatic bit advance_line();
    int unsigned h;
    int unsigned r;
    h = eff_size(cfg_rows, tccc_pkg::MaxRowsDef);
    r = cur_row + 1;
    cur_col = '0;
    if (r >= h) begin
      cur_row = 8'(r - 1);
      return 1'b1;
    end
    cur_row = 8'(r);
    return 1'b0;
  endfunction

  task automatic apply_char(input logic [7:0] c);
    int unsigned    w;
    int unsigned    h;
    tccc_pkg::res_t r[2];
    int             n;
    w = eff_size(cfg_columns, tccc_pkg::MaxColumnsDef);
    h = eff_size(cfg_rows, tccc_pkg::MaxRowsDef);
    n = 0;
    if (c == tccc_pkg::CharLf) begin
      if (advance_line()) begin
        r[0] = make_cmd(tccc_pkg::CmdScroll, '0, '0, '0, '0);
        n = 1;
      end
    end else if (c == tccc_pkg::CharCr) begin
      cur_col = '0;
    end else if (c == tccc_pkg::CharBs) begin
      if (cur_col > 0) begin
        cur_col = cur_col - 8'd1;
        r[0] = make_cmd(tccc_pkg::CmdDraw, tccc_pkg::CharSpace, cur_col, cur_row,
                        tccc_pkg::ColorBlack);
        n = 1;
      end else if (cur_row > 0) begin
        cur_row = cur_row - 8'd1;
        cur_col = 8'(w - 1);
        r[0] = make_cmd(tccc_pkg::CmdDraw, tccc_pkg::CharSpace, cur_col, cur_row,
                        tccc_pkg::ColorBlack);
        n = 1;
      end
    end else if (cur_col < w && cur_row < h) begin
      r[0] = make_cmd(tccc_pkg::CmdDraw, c, cur_col, cur_row, cfg_color);
      n = 1;
      if (cur_col + 1 >= w) begin
        if (advance_line()) begin
          r[1] = make_cmd(tccc_pkg::CmdScroll, '0, '0, '0, '0);
          n = 2;
        end
      end else begin
        cur_col = cur_col + 8'd1;
      end
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(r[i]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cmd.cmd   = tccc_pkg::cmd_e'(m_axis_tuser);
      got_cmd.glyph = m_axis_tdata[7:0];
      got_cmd.col   = m_axis_tdata[15:8];
      got_cmd.row   = m_axis_tdata[23:16];
      got_cmd.color = m_axis_tdata[47:24];
      got_cmd.last  = m_axis_tlast;
      if (expected_cmds.size() == 0) begin
        error_count++;
        $display("%0t: unexpected command cmd=%0d glyph=%h col=%0d row=%0d color=%h last=%0d",
                 $time, got_cmd.cmd, got_cmd.glyph, got_cmd.col, got_cmd.row,
                 got_cmd.color, got_cmd.last);
      end else begin
        want_cmd = expected_cmds.pop_front();
        if (got_cmd !== want_cmd) begin
          error_count++;
          $display("%0t: mismatch expected cmd=%0d glyph=%h col=%0d row=%0d color=%h last=%0d",
                   $time, want_cmd.cmd, want_cmd.glyph, want_cmd.col, want_cmd.row,
                   want_cmd.color, want_cmd.last);
          $display("%0t:          actual   cmd=%0d glyph=%h col=%0d row=%0d color=%h last=%0d",
                   $time, got_cmd.cmd, got_cmd.glyph, got_cmd.col, got_cmd.row,
                   got_cmd.color, got_cmd.last);
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_char(c);
  endtask

  // lets every expected command drain, then the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input tccc_pkg::reg_e idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_reg(input tccc_pkg::reg_e idx, input logic [31:0] want);
    logic [31:0] rdata;
    apb_xfer(1'b0, idx, '0, rdata);
    if (rdata !== want) begin
      error_count++;
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, want, rdata);
    end
  endtask

  task automatic write_reg(input tccc_pkg::reg_e idx, input logic [31:0] val);
    logic [31:0] rdata;
    apb_xfer(1'b1, idx, val, rdata);
    case (idx)
      tccc_pkg::RegColumns: begin
        cfg_columns = val[8:0];
        check_reg(idx, {23'd0, val[8:0]});
      end
      tccc_pkg::RegRows: begin
        cfg_rows = val[8:0];
        check_reg(idx, {23'd0, val[8:0]});
      end
      default: begin
        cfg_color = val[23:0];
        check_reg(idx, {8'd0, val[23:0]});
      end
    endcase
  endtask

  task automatic configure(input logic [31:0] cols, input logic [31:0] rows,
                           input logic [31:0] color);
    write_reg(tccc_pkg::RegColumns, cols);
    write_reg(tccc_pkg::RegRows, rows);
    write_reg(tccc_pkg::RegTextColor, color);
  endtask

  // mostly small sizes so that wraps and scrolls are frequent
  function automatic logic [31:0] pick_size();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 1;
      2: v = 2;
      3: v = 3;
      4, 5: v = $urandom_range(1, 8);
      6: v = $urandom_range(9, 80);
      7: v = 255;
      8: v = 256;
      default: v = $urandom_range(257, 511);
    endcase
    return v | ($urandom << 9);
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return tccc_pkg::CharLf;
    if (r < 20) return tccc_pkg::CharCr;
    if (r < 32) return tccc_pkg::CharBs;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_defaults();
    check_reg(tccc_pkg::RegColumns, {23'd0, tccc_pkg::ColumnsReset});
    check_reg(tccc_pkg::RegRows, {23'd0, tccc_pkg::RowsReset});
    check_reg(tccc_pkg::RegTextColor, {8'd0, tccc_pkg::TextColorReset});
    send_char(8'h41);
    send_char(tccc_pkg::CharBs);
    send_char(tccc_pkg::CharBs);
    send_char(tccc_pkg::CharCr);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(tccc_pkg::CharLf);
    wait_idle();
  endtask

  task automatic test_wrap_scroll();
    configure(2, 2, 32'h0012_3456);
    send_char(tccc_pkg::CharCr);
    send_char(8'h78);
    send_char(8'h79);
    send_char(8'h7A);
    send_char(8'h80);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharBs);
    send_char(tccc_pkg::CharBs);
    wait_idle();
  endtask

  task automatic test_register_limits();
    configure(0, 0, 32'h0000_0000);
    send_char(8'h51);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharBs);
    wait_idle();
    configure(511, 511, 32'hFFFF_FFFF);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharBs);
    send_char(8'h7E);
    send_char(tccc_pkg::CharLf);
    wait_idle();
  endtask

  task automatic test_cursor_outside();
    configure(256, 256, 32'h00A5_5A0F);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharLf);
    for (int i = 0; i < 5; i++) send_char(8'h61 + 8'(i));
    wait_idle();
    configure(4, 2, 32'h005A_A5F0);
    send_char(8'h66);
    send_char(tccc_pkg::CharBs);
    send_char(tccc_pkg::CharLf);
    send_char(tccc_pkg::CharCr);
    send_char(8'h67);
    wait_idle();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        wait_idle();
        configure(pick_size(), pick_size(),
                  ($urandom_range(0, 3) == 0) ? 32'h00FF_FFFF : $urandom);
      end
      send_char(pick_char());
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_wrap_scroll();
    test_register_limits();
    test_cursor_outside();
    test_random(470, 0, 0);
    test_random(470, 48, 0);
    test_random(470, 0, 48);
    test_random(470, 25, 25);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tccc_pkg.sv
rtl/tccc_cursor.sv
rtl/tccc_queue.sv
rtl/text_console_cursor_controller.sv
test/tb_text_console_cursor_controller.sv
